[rtl/atsc_pkg.sv]
// Shared types, codes and fixed widths of the traffic signal controller.
`timescale 1ns / 1ps

package atsc_pkg;

  // Fixed field widths
  localparam int CNT_W     = 6;   // lane counts, pedestrian counts, history entries
  localparam int GT_W      = 7;   // green time, phase tick counter
  localparam int TICK_W    = 4;   // yellow and all-red durations
  localparam int REQ_W     = 3;
  localparam int DIR_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 7;
  localparam int PRI_W     = 11;  // lane + 2*peds + emergency weight

  localparam logic [GT_W-1:0] MIN_GREEN_RESET = 7'd10;
  localparam logic [GT_W-1:0] MAX_GREEN_RESET = 7'd120;
  localparam logic [TICK_W-1:0] YELLOW_RESET  = 4'd3;
  localparam logic [TICK_W-1:0] ALL_RED_RESET = 4'd2;
  localparam logic [CNT_W-1:0] CONGEST_RESET  = 6'd42;

  localparam int EMG_WEIGHT = 1000;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ARRIVE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PED       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_EMG_START = 3'd3;
  localparam logic [REQ_W-1:0] REQ_EMG_CLEAR = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GREEN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GREEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALL_RED_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONGEST_LIMIT = 3'd4;

  typedef enum logic [1:0] {
    LT_RED    = 2'd0,
    LT_YELLOW = 2'd1,
    LT_GREEN  = 2'd2,
    LT_BLINK  = 2'd3
  } light_t;

endpackage

[rtl/atsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module atsc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 40,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/atsc_green_calc.sv]
// Adaptive green time from lane count, history sum and waiting pedestrians.
`timescale 1ns / 1ps

module atsc_green_calc #(
  parameter int QUEUE_CAPACITY = 50,
  parameter int HISTORY_DEPTH  = 10,
  localparam int SumW = $clog2(HISTORY_DEPTH * QUEUE_CAPACITY + 1)
) (
  input  logic [atsc_pkg::CNT_W-1:0] count,      // already capped at capacity
  input  logic [SumW-1:0]            hist_sum,   // includes the newest entry
  input  logic [atsc_pkg::CNT_W-1:0] peds,
  input  logic [atsc_pkg::GT_W-1:0]  min_green,
  input  logic [atsc_pkg::GT_W-1:0]  max_green,
  output logic [atsc_pkg::GT_W-1:0]  green
);

  import atsc_pkg::*;

  localparam int ExtW = SumW + 1;
  localparam int GW   = GT_W + 1;     // headroom for bonuses before clamping
  localparam int TabN = 1 << CNT_W;

  localparam logic [GW-1:0] ADJ_STEP     = 8'd5;
  localparam logic [GW-1:0] PED_BONUS_LO = 8'd5;
  localparam logic [GW-1:0] PED_BONUS_HI = 8'd10;
  localparam logic [CNT_W-1:0] PED_MANY  = 6'd5;

  // Load bonus per count, floor((10c - 3Q) * 4 / Q) when 10c > 3Q, else zero, resolved at elaboration
  logic [4:0] bonus_tab [TabN];

  for (genvar i = 0; i < TabN; i++) begin : g_bonus
    localparam int B = (10 * i > 3 * QUEUE_CAPACITY) ?
                       ((10 * i - 3 * QUEUE_CAPACITY) * 4) / QUEUE_CAPACITY : 0;
    assign bonus_tab[i] = 5'(B);
  end

  logic [ExtW-1:0] sum_ext;
  logic [ExtW-1:0] sum_dbl;
  logic [ExtW-1:0] hc;
  logic [GW-1:0]   min_ext;
  logic [GW-1:0]   max_ext;
  logic [GW-1:0]   g_load;
  logic [GW-1:0]   g_hist;
  logic [GW-1:0]   g_ped;
  logic [GW-1:0]   g_hi;
  logic [GW-1:0]   g_lo;

  always_comb begin
    sum_ext = ExtW'(hist_sum);
    sum_dbl = {hist_sum, 1'b0};
    hc      = ExtW'(count) * ExtW'(HISTORY_DEPTH);
    min_ext = GW'(min_green);
    max_ext = GW'(max_green);
    g_load  = min_ext + GW'(bonus_tab[count]);

    if (sum_ext > hc) begin
      g_hist = g_load + ADJ_STEP;
    end else if (sum_dbl < hc) begin
      g_hist = (g_load > min_ext + ADJ_STEP) ? g_load - ADJ_STEP : min_ext;
    end else begin
      g_hist = g_load;
    end

    if (peds == '0) begin
      g_ped = g_hist;
    end else begin
      g_ped = g_hist + ((peds > PED_MANY) ? PED_BONUS_HI : PED_BONUS_LO);
    end

    // max clamp first, so inverted clamps end at min_green
    g_hi  = (g_ped > max_ext) ? max_ext : g_ped;
    g_lo  = (g_hi < min_ext) ? min_ext : g_hi;
    green = g_lo[GT_W-1:0];
  end

endmodule

[rtl/adaptive_traffic_signal_controller_core.sv]
// Top level of the adaptive four-way traffic signal controller.
`timescale 1ns / 1ps

// Each input item is one event (tick, vehicle arrival, pedestrian request,
// emergency start or clear) and yields exactly one result item showing the
// lights, the served direction, the phase and flags after that event. The
// block takes one item per clock while the output does not stall; a result
// item passes the input register, then the result register. One item more
// is taken while a result waits on a stalled output. Unless frozen by
// emergency preemption or quiet-night blinking, ticks step the phase
// rotation green -> yellow -> all-red -> select. On the select step the
// served lane's capped count goes into its ten-deep history, green time is
// recomputed from count, running history sum and waiting pedestrians, and
// green passes to the busiest other direction (emergency flags weigh most).
// The history lives in a small RAM; the entry due to be replaced is read
// ahead of time, which works because two select steps are always at least
// three ticks apart. History entries carry valid bits cleared by reset, so
// there is no clearing pass. Configuration writes are always ready and are
// meant to be made while the block is idle.
module adaptive_traffic_signal_controller_core #(
  parameter int LANES           = 4,
  parameter int QUEUE_CAPACITY  = 50,
  parameter int HISTORY_DEPTH   = 10,
  parameter int EMERGENCY_SLOTS = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [atsc_pkg::REQ_W-1:0]     req_type,
  input  logic [atsc_pkg::DIR_W-1:0]     direction,
  input  logic                           night,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     light_north,
  output logic [1:0]                     light_south,
  output logic [1:0]                     light_east,
  output logic [1:0]                     light_west,
  output logic [1:0]                     green_direction,
  output logic [1:0]                     phase,
  output logic                           accepted,
  output logic                           emergency_mode,
  output logic                           congestion,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [atsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [atsc_pkg::CFG_DAT_W-1:0] cfg_data
);

  import atsc_pkg::*;

  localparam int LW   = $clog2(LANES);
  localparam int HPW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HD   = LANES * HISTORY_DEPTH;
  localparam int AW   = $clog2(HD);
  localparam int SumW = $clog2(HISTORY_DEPTH * QUEUE_CAPACITY + 1);
  localparam int EW   = $clog2(EMERGENCY_SLOTS + 1);
  localparam logic DIR_ALL = (LANES >= 4);

  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_ALLRED = 2'd2,
    PH_SELECT = 2'd3
  } phase_t;

  // configuration
  logic [GT_W-1:0]   min_green;
  logic [GT_W-1:0]   max_green;
  logic [TICK_W-1:0] yellow_ticks;
  logic [TICK_W-1:0] all_red_ticks;
  logic [CNT_W-1:0]  congest_limit;

  // input register
  logic             in_q_valid;
  logic [REQ_W-1:0] q_req;
  logic [DIR_W-1:0] q_dir;
  logic             q_night;

  // controller state
  logic [CNT_W-1:0] lane_count   [LANES];
  logic [CNT_W-1:0] total_queued;
  logic [CNT_W-1:0] peds_waiting [LANES];
  logic [GT_W-1:0]  green_len    [LANES];
  logic [SumW-1:0]  hist_sum     [LANES];
  logic [HPW-1:0]   hist_ptr     [LANES];
  logic [LW-1:0]    served;
  phase_t           rot_step;
  logic [GT_W-1:0]  phase_ticks;
  logic [LANES-1:0] emg_flag;
  logic [EW-1:0]    emg_active;
  light_t           light_state  [LANES];
  logic [HD-1:0]    hist_valid;
  logic             rd_valid;

  // next values
  logic [CNT_W-1:0] lane_next    [LANES];
  logic [CNT_W-1:0] total_next;
  logic [CNT_W-1:0] peds_next    [LANES];
  logic [GT_W-1:0]  gt_next      [LANES];
  logic [SumW-1:0]  sum_next     [LANES];
  logic [HPW-1:0]   ptr_next     [LANES];
  logic [LW-1:0]    served_next;
  phase_t           phase_next;
  logic [GT_W-1:0]  ticks_next;
  logic [LANES-1:0] flag_next;
  logic [EW-1:0]    active_next;
  light_t           light_next   [LANES];
  logic             accepted_next;
  logic             congest_next;
  light_t           lt_out       [4];

  // datapath helpers
  logic             out_ready;
  logic             fire;
  logic [LW-1:0]    cur;
  logic [LW-1:0]    dir_i;
  logic             dir_ok;
  logic             congested_now;
  logic [GT_W-1:0]  ticks_bump;
  logic [CNT_W-1:0] rel_cnt;
  logic [CNT_W-1:0] c_cap;
  logic [CNT_W-1:0] old_entry;
  logic [SumW-1:0]  sum_new;
  logic [GT_W-1:0]  green_new;
  logic [HPW-1:0]   ptr_inc;
  logic [AW-1:0]    hist_addr;
  logic [CNT_W-1:0] rd_data;
  logic             hist_we;
  logic [PRI_W-1:0] best;
  logic [PRI_W-1:0] pr;
  logic [LW-1:0]    best_dir;

  // handshakes: input register parts the input from the result register
  assign out_ready = !out_valid || !out_stall;
  assign fire      = in_q_valid && out_ready;
  assign in_stall  = in_q_valid && !out_ready;
  assign cfg_ready = 1'b1;

  assign cur    = served;
  assign dir_i  = LW'(q_dir);
  assign dir_ok = DIR_ALL || (int'(q_dir) < LANES);

  always_comb begin
    congested_now = 1'b0;
    for (int d = 0; d < LANES; d++) begin
      if (lane_count[d] > congest_limit) begin
        congested_now = 1'b1;
      end
    end
  end

  assign ticks_bump = (phase_ticks == '1) ? phase_ticks : phase_ticks + 7'd1;
  // green end releases count/2+1 vehicles, never more than are queued
  assign rel_cnt = (lane_count[cur] == '0) ? '0 : (lane_count[cur] >> 1) + 6'd1;
  assign c_cap   = (lane_count[cur] > CNT_W'(QUEUE_CAPACITY)) ?
                   CNT_W'(QUEUE_CAPACITY) : lane_count[cur];

  // history entry being replaced, read ahead at the current pointer
  assign hist_addr = AW'(cur) * AW'(HISTORY_DEPTH) + AW'(hist_ptr[cur]);
  assign old_entry = rd_valid ? rd_data : '0;
  assign sum_new   = hist_sum[cur] - SumW'(old_entry) + SumW'(c_cap);
  assign ptr_inc   = (hist_ptr[cur] == HPW'(HISTORY_DEPTH - 1)) ?
                     '0 : hist_ptr[cur] + 1'b1;

  atsc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HD)
  ) u_hist_ram (
    .clk   (clk),
    .we    (fire && hist_we),
    .waddr (hist_addr),
    .wdata (c_cap),
    .raddr (hist_addr),
    .rdata (rd_data)
  );

  atsc_green_calc #(
    .QUEUE_CAPACITY (QUEUE_CAPACITY),
    .HISTORY_DEPTH  (HISTORY_DEPTH)
  ) u_green_calc (
    .count     (c_cap),
    .hist_sum  (sum_new),
    .peds      (peds_waiting[cur]),
    .min_green (min_green),
    .max_green (max_green),
    .green     (green_new)
  );

  // next served direction: highest priority among the others, ties to lowest; all zero: the one after cur
  always_comb begin
    best     = '0;
    pr       = '0;
    best_dir = (cur == LW'(LANES - 1)) ? '0 : cur + 1'b1;
    for (int d = 0; d < LANES; d++) begin
      if (LW'(d) != cur) begin
        pr = PRI_W'(lane_count[d]) + (PRI_W'(peds_waiting[d]) << 1) +
             (emg_flag[d] ? PRI_W'(EMG_WEIGHT) : '0);
        if (pr > best) begin
          best     = pr;
          best_dir = LW'(d);
        end
      end
    end
  end

  always_comb begin
    lane_next     = lane_count;
    total_next    = total_queued;
    peds_next     = peds_waiting;
    gt_next       = green_len;
    sum_next      = hist_sum;
    ptr_next      = hist_ptr;
    served_next   = served;
    phase_next    = rot_step;
    ticks_next    = phase_ticks;
    flag_next     = emg_flag;
    active_next   = emg_active;
    light_next    = light_state;
    accepted_next = 1'b0;
    hist_we       = 1'b0;

    case (q_req)
      REQ_TICK: begin
        if (emg_active != '0) begin
          // preemption: rotation frozen
          for (int d = 0; d < LANES; d++) begin
            light_next[d] = emg_flag[d] ? LT_GREEN : LT_RED;
          end
        end else if (congested_now || !q_night) begin
          case (rot_step)
            PH_GREEN: begin
              for (int d = 0; d < LANES; d++) begin
                light_next[d] = (LW'(d) == cur) ? LT_GREEN : LT_RED;
              end
              ticks_next = ticks_bump;
              if (ticks_bump >= green_len[cur]) begin
                lane_next[cur] = lane_count[cur] - rel_cnt;
                total_next     = (total_queued > rel_cnt) ? total_queued - rel_cnt : '0;
                ticks_next     = '0;
                phase_next     = PH_YELLOW;
              end
            end
            PH_YELLOW: begin
              light_next[cur] = LT_YELLOW;
              ticks_next      = ticks_bump;
              if (ticks_bump >= GT_W'(yellow_ticks)) begin
                ticks_next = '0;
                phase_next = PH_ALLRED;
              end
            end
            PH_ALLRED: begin
              light_next[cur] = LT_RED;
              ticks_next      = ticks_bump;
              if (ticks_bump >= GT_W'(all_red_ticks)) begin
                ticks_next = '0;
                phase_next = PH_SELECT;
              end
            end
            PH_SELECT: begin
              hist_we       = 1'b1;
              ptr_next[cur] = ptr_inc;
              sum_next[cur] = sum_new;
              gt_next[cur]  = green_new;
              served_next   = best_dir;
              phase_next    = PH_GREEN;
            end
            default: begin
            end
          endcase
        end else begin
          // night: blinking yellow, rotation frozen
          for (int d = 0; d < LANES; d++) begin
            light_next[d] = LT_BLINK;
          end
        end
      end
      REQ_ARRIVE: begin
        if (dir_ok && (total_queued < CNT_W'(QUEUE_CAPACITY))) begin
          total_next = total_queued + 6'd1;
          if (lane_count[dir_i] != '1) begin
            lane_next[dir_i] = lane_count[dir_i] + 6'd1;
          end
          accepted_next = 1'b1;
        end
      end
      REQ_PED: begin
        if (dir_ok && (peds_waiting[dir_i] != '1)) begin
          peds_next[dir_i] = peds_waiting[dir_i] + 6'd1;
        end
      end
      REQ_EMG_START: begin
        if (dir_ok && (emg_active < EW'(EMERGENCY_SLOTS))) begin
          flag_next[dir_i] = 1'b1;
          active_next      = emg_active + 1'b1;
          accepted_next    = 1'b1;
        end
      end
      REQ_EMG_CLEAR: begin
        if (dir_ok) begin
          flag_next[dir_i] = 1'b0;
          if (emg_active != '0) begin
            active_next = emg_active - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    congest_next = 1'b0;
    for (int d = 0; d < LANES; d++) begin
      if (lane_next[d] > congest_limit) begin
        congest_next = 1'b1;
      end
    end
  end

  // reported lights: approaches beyond LANES read red
  for (genvar d = 0; d < 4; d++) begin : g_lt_out
    if (d < LANES) begin : g_real
      assign lt_out[d] = light_next[d];
    end else begin : g_none
      assign lt_out[d] = LT_RED;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_green     <= MIN_GREEN_RESET;
      max_green     <= MAX_GREEN_RESET;
      yellow_ticks  <= YELLOW_RESET;
      all_red_ticks <= ALL_RED_RESET;
      congest_limit <= CONGEST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_GREEN:     min_green     <= cfg_data[GT_W-1:0];
        CFG_MAX_GREEN:     max_green     <= cfg_data[GT_W-1:0];
        CFG_YELLOW_TICKS:  yellow_ticks  <= cfg_data[TICK_W-1:0];
        CFG_ALL_RED_TICKS: all_red_ticks <= cfg_data[TICK_W-1:0];
        CFG_CONGEST_LIMIT: congest_limit <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_req   <= req_type;
      q_dir   <= direction;
      q_night <= night;
    end
    rd_valid <= hist_valid[hist_addr];
  end

  // controller state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid   <= 1'b0;
      out_valid    <= 1'b0;
      total_queued <= '0;
      served       <= '0;
      rot_step     <= PH_GREEN;
      phase_ticks  <= '0;
      emg_flag     <= '0;
      emg_active   <= '0;
      hist_valid   <= '0;
      for (int d = 0; d < LANES; d++) begin
        lane_count[d]   <= '0;
        peds_waiting[d] <= '0;
        green_len[d]    <= MIN_GREEN_RESET;
        hist_sum[d]     <= '0;
        hist_ptr[d]     <= '0;
        light_state[d]  <= LT_RED;
      end
    end else begin
      if (in_valid && !in_stall) begin
        in_q_valid <= 1'b1;
      end else if (fire) begin
        in_q_valid <= 1'b0;
      end

      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (fire) begin
        lane_count   <= lane_next;
        total_queued <= total_next;
        peds_waiting <= peds_next;
        green_len    <= gt_next;
        hist_sum     <= sum_next;
        hist_ptr     <= ptr_next;
        served       <= served_next;
        rot_step     <= phase_next;
        phase_ticks  <= ticks_next;
        emg_flag     <= flag_next;
        emg_active   <= active_next;
        light_state  <= light_next;
        if (hist_we) begin
          hist_valid[hist_addr] <= 1'b1;
        end

        light_north     <= lt_out[0];
        light_south     <= lt_out[1];
        light_east      <= lt_out[2];
        light_west      <= lt_out[3];
        green_direction <= 2'(served_next);
        phase           <= phase_next;
        accepted        <= accepted_next;
        emergency_mode  <= (active_next != '0);
        congestion      <= congest_next;
      end
    end
  end

`ifndef SYNTHESIS
  // the served direction moves only on a select step
  a_served_hold: assert property (@(posedge clk) disable iff (rst)
    fire && (rot_step != PH_SELECT) |=> $stable(served))
    else $error("served direction changed outside select step");

  // a ticked select step always returns to green
  a_select_to_green: assert property (@(posedge clk) disable iff (rst)
    fire && (rot_step == PH_SELECT) && (q_req == REQ_TICK) && (emg_active == '0) &&
    (congested_now || !q_night) |=> (rot_step == PH_GREEN))
    else $error("select step did not return to green");

  // reported emergency flag tracks the slot count
  a_emg_report: assert property (@(posedge clk) disable iff (rst)
    fire |=> (emergency_mode == (emg_active != '0)))
    else $error("emergency_mode disagrees with active slot count");

  // slot count never passes the number of slots
  a_emg_bound: assert property (@(posedge clk) disable iff (rst)
    fire |=> (emg_active <= EW'(EMERGENCY_SLOTS)))
    else $error("emergency slot count overflow");
`endif

endmodule

[test/tb_adaptive_traffic_signal_controller_core.sv]
// Self-checking testbench for the adaptive traffic signal controller core.
`timescale 1ns / 1ps

import atsc_pkg::*;

typedef enum logic [1:0] {
  PH_GREEN   = 2'd0,
  PH_YELLOW  = 2'd1,
  PH_ALL_RED = 2'd2,
  PH_SELECT  = 2'd3
} phase_t;

// One result item as seen on the output ports.
typedef struct packed {
  light_t     north;
  light_t     south;
  light_t     east;
  light_t     west;
  logic [1:0] green_dir;
  logic [1:0] phase;
  logic       acc;
  logic       emg;
  logic       cong;
} signal_view_t;

// Mirrors the controller state, predicts the result of every taken item
// and checks each result item against the oldest prediction.
class signal_scoreboard;
  localparam int NLANES      = 4;
  localparam int QCAP        = 50;
  localparam int HDEPTH      = 10;
  localparam int EMG_SLOTS   = 5;

  // register copies
  bit [GT_W-1:0]   min_green;
  bit [GT_W-1:0]   max_green;
  bit [TICK_W-1:0] yellow_len;
  bit [TICK_W-1:0] all_red_len;
  bit [CNT_W-1:0]  congest_lim;

  // controller state
  bit [CNT_W-1:0]  lanes[NLANES];
  bit [CNT_W-1:0]  queued;
  bit [CNT_W-1:0]  peds[NLANES];
  bit [GT_W-1:0]   gtime[NLANES];
  bit [CNT_W-1:0]  hist[NLANES][HDEPTH];
  bit [3:0]        hist_ptr[NLANES];
  bit [1:0]        served;
  phase_t          step;
  bit [GT_W-1:0]   ticks;
  bit              flag[NLANES];
  bit [2:0]        emg_count;
  light_t          lamp[NLANES];

  signal_view_t    expected_views[$];
  int              mismatches;
  int              results_seen;
  int              arrivals_refused;
  int              emg_refused;
  int              handoffs;

  function new();
    int d;
    int i;
    min_green   = MIN_GREEN_RESET;
    max_green   = MAX_GREEN_RESET;
    yellow_len  = YELLOW_RESET;
    all_red_len = ALL_RED_RESET;
    congest_lim = CONGEST_RESET;
    for (d = 0; d < NLANES; d++) begin
      lanes[d]    = '0;
      peds[d]     = '0;
      gtime[d]    = MIN_GREEN_RESET;
      hist_ptr[d] = '0;
      flag[d]     = 1'b0;
      lamp[d]     = LT_RED;
      for (i = 0; i < HDEPTH; i++) hist[d][i] = '0;
    end
    queued           = '0;
    served           = '0;
    step             = PH_GREEN;
    ticks            = '0;
    emg_count        = '0;
    mismatches       = 0;
    results_seen     = 0;
    arrivals_refused = 0;
    emg_refused      = 0;
    handoffs         = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    case (idx)
      CFG_MIN_GREEN:     min_green   = val[GT_W-1:0];
      CFG_MAX_GREEN:     max_green   = val[GT_W-1:0];
      CFG_YELLOW_TICKS:  yellow_len  = val[TICK_W-1:0];
      CFG_ALL_RED_TICKS: all_red_len = val[TICK_W-1:0];
      CFG_CONGEST_LIMIT: congest_lim = val[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function bit is_congested();
    int d;
    for (d = 0; d < NLANES; d++)
      if (lanes[d] > congest_lim) return 1'b1;
    return 1'b0;
  endfunction

  function int compute_green(int d);
    int c;
    int s;
    int g;
    int i;
    c = (lanes[d] > QCAP) ? QCAP : int'(lanes[d]);
    s = 0;
    for (i = 0; i < HDEPTH; i++) s += hist[d][i];
    g = min_green;
    if (10 * c > 3 * QCAP) g += (10 * c - 3 * QCAP) * 4 / QCAP;
    if (s > HDEPTH * c) g += 5;
    else if (2 * s < HDEPTH * c) g = (g > min_green + 5) ? g - 5 : int'(min_green);
    if (peds[d] > 0) g += (peds[d] > 5) ? 10 : 5;
    if (g > max_green) g = max_green;
    if (g < min_green) g = min_green;
    return g & 127;
  endfunction

  function void bump_ticks();
    if (ticks < 127) ticks = ticks + 1'b1;
  endfunction

  // one tick of the green -> yellow -> all-red -> select rotation
  function void advance_phase();
    int cur;
    int d;
    int r;
    int p;
    int best;
    int nxt;
    int pr;
    cur = served;
    case (step)
      PH_GREEN: begin
        for (d = 0; d < NLANES; d++) lamp[d] = (d == cur) ? LT_GREEN : LT_RED;
        bump_ticks();
        if (ticks >= gtime[cur]) begin
          // green end: served lane drains half its queue plus one
          r = lanes[cur] / 2 + 1;
          if (r > lanes[cur]) r = lanes[cur];
          lanes[cur] = CNT_W'(lanes[cur] - r);
          queued = (queued > r) ? CNT_W'(queued - r) : '0;
          ticks = '0;
          step = PH_YELLOW;
        end
      end
      PH_YELLOW: begin
        lamp[cur] = LT_YELLOW;
        bump_ticks();
        if (ticks >= yellow_len) begin
          ticks = '0;
          step = PH_ALL_RED;
        end
      end
      PH_ALL_RED: begin
        lamp[cur] = LT_RED;
        bump_ticks();
        if (ticks >= all_red_len) begin
          ticks = '0;
          step = PH_SELECT;
        end
      end
      default: begin
        p = hist_ptr[cur];
        if (p >= HDEPTH) p = 0;
        hist[cur][p] = (lanes[cur] > QCAP) ? CNT_W'(QCAP) : lanes[cur];
        hist_ptr[cur] = 4'((p + 1) % HDEPTH);
        gtime[cur] = GT_W'(compute_green(cur));
        nxt = (cur + 1) % NLANES;
        best = 0;
        for (d = 0; d < NLANES; d++) begin
          if (d == cur) continue;
          pr = lanes[d] + 2 * peds[d];
          if (flag[d]) pr += EMG_WEIGHT;
          if (pr > best) begin
            best = pr;
            nxt = d;
          end
        end
        served = 2'(nxt);
        step = PH_GREEN;
        handoffs++;
      end
    endcase
  endfunction

  // Called for every taken input item: updates the mirror, queues the view.
  function void note_item(logic [REQ_W-1:0] req, logic [DIR_W-1:0] dir, logic nite);
    signal_view_t v;
    bit took;
    int d;
    took = 1'b0;
    case (req)
      REQ_TICK: begin
        if (emg_count != 0) begin
          for (d = 0; d < NLANES; d++) lamp[d] = flag[d] ? LT_GREEN : LT_RED;
        end else if (is_congested() || !nite) begin
          advance_phase();
        end else begin
          for (d = 0; d < NLANES; d++) lamp[d] = LT_BLINK;
        end
      end
      REQ_ARRIVE: begin
        if (queued < QCAP) begin
          queued = queued + 1'b1;
          if (lanes[dir] < 63) lanes[dir] = lanes[dir] + 1'b1;
          took = 1'b1;
        end else begin
          arrivals_refused++;
        end
      end
      REQ_PED: begin
        if (peds[dir] < 63) peds[dir] = peds[dir] + 1'b1;
      end
      REQ_EMG_START: begin
        if (emg_count < EMG_SLOTS) begin
          flag[dir] = 1'b1;
          emg_count = emg_count + 1'b1;
          took = 1'b1;
        end else begin
          emg_refused++;
        end
      end
      REQ_EMG_CLEAR: begin
        flag[dir] = 1'b0;
        if (emg_count != 0) emg_count = emg_count - 1'b1;
      end
      default: ;  // unknown codes change nothing
    endcase
    v.north     = lamp[0];
    v.south     = lamp[1];
    v.east      = lamp[2];
    v.west      = lamp[3];
    v.green_dir = served;
    v.phase     = step;
    v.acc       = took;
    v.emg       = (emg_count != 0);
    v.cong      = is_congested();
    expected_views.push_back(v);
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task check_field(string name, logic [1:0] got, logic [1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task check_result(signal_view_t got);
    signal_view_t want;
    if (expected_views.size() == 0) begin
      report_mismatch("result item with no input item waiting");
      return;
    end
    want = expected_views.pop_front();
    check_field("light_north", got.north, want.north);
    check_field("light_south", got.south, want.south);
    check_field("light_east", got.east, want.east);
    check_field("light_west", got.west, want.west);
    check_field("green_direction", got.green_dir, want.green_dir);
    check_field("phase", got.phase, want.phase);
    check_field("accepted", {1'b0, got.acc}, {1'b0, want.acc});
    check_field("emergency_mode", {1'b0, got.emg}, {1'b0, want.emg});
    check_field("congestion", {1'b0, got.cong}, {1'b0, want.cong});
    results_seen++;
  endtask

  function int pending();
    return expected_views.size();
  endfunction
endclass

module tb_adaptive_traffic_signal_controller_core;

  localparam int  LONG_HOLD  = 400;        // receiver hold-off, cycles
  localparam time TIMEOUT_NS = 5_000_000;  // far above the slowest legal run

  typedef enum int {
    MIX_NONE,      // nobody idles
    MIX_SENDER,    // sender idles about half the cycles
    MIX_RECEIVER,  // receiver stalls about half the cycles
    MIX_BOTH       // both idle a little
  } idle_mix_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type;
  logic [DIR_W-1:0]     direction;
  logic                 night;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           light_north;
  logic [1:0]           light_south;
  logic [1:0]           light_east;
  logic [1:0]           light_west;
  logic [1:0]           green_direction;
  logic [1:0]           phase;
  logic                 accepted;
  logic                 emergency_mode;
  logic                 congestion;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  signal_scoreboard sb;
  signal_view_t     seen_view;

  int send_pct;     // chance per cycle that the sender idles after an item
  int recv_pct;     // chance per cycle that the receiver stalls
  int hold_seq;     // bumped to ask the receiver for one long hold-off
  int items_sent;   // every item taken, ignored codes included
  int phase_items;  // items of the current phase that do something
  int settings_run;

  adaptive_traffic_signal_controller_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .direction       (direction),
    .night           (night),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .light_north     (light_north),
    .light_south     (light_south),
    .light_east      (light_east),
    .light_west      (light_west),
    .green_direction (green_direction),
    .phase           (phase),
    .accepted        (accepted),
    .emergency_mode  (emergency_mode),
    .congestion      (congestion),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitors sample at the clock edge, so they see pre-edge values.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_item(req_type, direction, night);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_view.north     = light_t'(light_north);
      seen_view.south     = light_t'(light_south);
      seen_view.east      = light_t'(light_east);
      seen_view.west      = light_t'(light_west);
      seen_view.green_dir = green_direction;
      seen_view.phase     = phase;
      seen_view.acc       = accepted;
      seen_view.emg       = emergency_mode;
      seen_view.cong      = congestion;
      sb.check_result(seen_view);
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  // Receiver: random stalls, plus a long counted hold-off on request.
  initial begin
    int left;
    int seen;
    left = 0;
    seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        left = LONG_HOLD;
      end
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d result items still expected", sb.pending());
    $display("Regression FAIL");
    $finish;
  end

  task set_idle(idle_mix_t mix);
    case (mix)
      MIX_NONE:     begin send_pct = 0;  recv_pct <= 0;  end
      MIX_SENDER:   begin send_pct = 51; recv_pct <= 0;  end
      MIX_RECEIVER: begin send_pct = 0;  recv_pct <= 51; end
      default:      begin send_pct = 9;  recv_pct <= 9;  end
    endcase
  endtask

  // Offer one item and hold it until taken; valid stays high into the
  // next item unless the sender decides to idle.
  task send_item(logic [REQ_W-1:0] req, logic [DIR_W-1:0] dir, logic nite);
    int gap;
    req_type  <= req;
    direction <= dir;
    night     <= nite;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (req <= REQ_EMG_CLEAR) phase_items++;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every expected result item.
  task drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DAT_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task apply_settings(int min_g, int max_g, int yel, int all_red, int cong);
    write_cfg(CFG_MIN_GREEN, min_g);
    write_cfg(CFG_MAX_GREEN, max_g);
    write_cfg(CFG_YELLOW_TICKS, yel);
    write_cfg(CFG_ALL_RED_TICKS, all_red);
    write_cfg(CFG_CONGEST_LIMIT, cong);
    cfg_valid <= 1'b0;
    settings_run++;
    phase_items = 0;
  endtask

  function logic [DIR_W-1:0] any_dir();
    return DIR_W'($urandom_range(3));
  endfunction

  function logic [REQ_W-1:0] mixed_req();
    int r;
    r = $urandom_range(99);
    if (r < 50) return REQ_TICK;
    if (r < 75) return REQ_ARRIVE;
    if (r < 85) return REQ_PED;
    if (r < 92) return REQ_EMG_START;
    return REQ_EMG_CLEAR;
  endfunction

  // Edge cases first: reset view, every request code, emergency override,
  // double clear, night blink, unknown codes, full emergency slots.
  task directed_items;
    int d;
    int u;
    send_item(REQ_TICK, 2'd0, 1'b0);
    for (d = 0; d < 4; d++) send_item(REQ_ARRIVE, DIR_W'(d), 1'b0);
    send_item(REQ_PED, 2'd3, 1'b1);
    send_item(REQ_EMG_START, 2'd2, 1'b0);
    send_item(REQ_TICK, 2'd1, 1'b1);       // emergency wins over night
    send_item(REQ_EMG_CLEAR, 2'd2, 1'b0);
    send_item(REQ_EMG_CLEAR, 2'd2, 1'b0);  // count already zero
    send_item(REQ_TICK, 2'd0, 1'b1);       // quiet night: blinking yellow
    for (u = REQ_EMG_CLEAR + 1; u < 8; u++) send_item(REQ_W'(u), 2'd3, 1'b1);
    for (d = 0; d < 6; d++) send_item(REQ_EMG_START, DIR_W'(d % 4), 1'b0);  // last refused
    send_item(REQ_TICK, 2'd3, 1'b0);
    for (d = 0; d < 5; d++) send_item(REQ_EMG_CLEAR, DIR_W'(d % 4), 1'b0);
    send_item(REQ_TICK, 2'd0, 1'b0);
  endtask

  // Random traffic made of short scenarios; idle mix rotates every 40 items.
  task run_traffic(int target);
    int kind;
    int len;
    int i;
    int n;
    int next_switch;
    idle_mix_t mix;
    logic [DIR_W-1:0] emg_dirs[6];
    mix = MIX_NONE;
    next_switch = 40;
    set_idle(mix);
    while (phase_items < target) begin
      if (phase_items >= next_switch) begin
        mix = idle_mix_t'((int'(mix) + 1) % 4);
        set_idle(mix);
        next_switch += 40;
      end
      kind = $urandom_range(99);
      if (kind < 45) begin
        // everyday mix, tick heavy so the rotation keeps moving
        len = $urandom_range(8, 20);
        for (i = 0; i < len; i++)
          send_item(mixed_req(), any_dir(), $urandom_range(99) < 25);
      end else if (kind < 60) begin
        // rush of arrivals, enough to hit the capacity limit
        len = $urandom_range(10, 40);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(99) < 20) send_item(REQ_TICK, any_dir(), 1'b0);
          else send_item(REQ_ARRIVE, any_dir(), 1'b0);
        end
      end else if (kind < 72) begin
        // emergency episode: some starts, a few ticks, matching clears
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          emg_dirs[i] = any_dir();
          send_item(REQ_EMG_START, emg_dirs[i], 1'b0);
        end
        len = $urandom_range(3, 8);
        for (i = 0; i < len; i++) send_item(REQ_TICK, any_dir(), 1'($urandom_range(1)));
        for (i = 0; i < n; i++) send_item(REQ_EMG_CLEAR, emg_dirs[i], 1'b0);
        if ($urandom_range(3) == 0) send_item(REQ_EMG_CLEAR, any_dir(), 1'b0);
      end else if (kind < 85) begin
        // night stretch with stray traffic
        len = $urandom_range(10, 25);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(99) < 75) send_item(REQ_TICK, any_dir(), 1'b1);
          else send_item(REQ_ARRIVE, any_dir(), 1'b1);
        end
      end else begin
        // noise over the whole code space
        len = $urandom_range(3, 8);
        for (i = 0; i < len; i++)
          send_item(REQ_W'($urandom_range(7)), any_dir(), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    sb = new();
    send_pct     = 0;
    hold_seq     = 0;
    items_sent   = 0;
    phase_items  = 0;
    settings_run = 1;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    req_type  <= REQ_TICK;
    direction <= '0;
    night     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MIN_GREEN;
    cfg_data  <= '0;
    recv_pct  <= 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    phase_items = 0;
    run_traffic(120);            // reset register values
    drain();

    apply_settings(1, 127, 1, 1, 0);      // shortest phases, congestion at one car
    run_traffic(150);
    drain();

    apply_settings(1, 1, 1, 1, 25);       // fixed one-tick green
    run_traffic(150);
    drain();

    apply_settings(127, 1, 15, 15, 50);   // inverted clamps, longest phases
    run_traffic(80);
    drain();

    apply_settings(5, 40, 2, 3, 10);
    hold_seq <= hold_seq + 1;             // receiver holds off, input backs up
    run_traffic(100);
    drain();

    apply_settings($urandom_range(1, 127), $urandom_range(1, 127),
                   $urandom_range(1, 15), $urandom_range(1, 15), $urandom_range(0, 50));
    run_traffic(100);
    drain();
    repeat (10) @(posedge clk);

    $display("Ran %0d items through %0d register settings and four idle mixes;",
             items_sent, settings_run);
    $display("%0d green handoffs, %0d arrivals and %0d emergency starts refused, %0d mismatches.",
             sb.handoffs, sb.arrivals_refused, sb.emg_refused, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
